### rtl/core/assert_macros.svh
// Assertion helpers for the bound checker facp_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// Next-cycle implication, off while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

### rtl/core/facp_pkg.sv
package facp_pkg;

   localparam int TAG_W  = 32;
   localparam int WORD_W = 64;
   localparam int OP_W   = 2;
   localparam int STAT_W = 2;
   localparam int OFF_W  = 3;
   localparam int CNT_W  = 4;

   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_FILL  = 2'd2;

   localparam logic [STAT_W-1:0] STAT_HIT     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_MISS    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;
   localparam logic [STAT_W-1:0] STAT_FILLED  = 2'd3;

   // Low n byte lanes set; all lanes for n of 8 or more.
   function automatic logic [WORD_W-1:0] lane_mask(input logic [CNT_W-1:0] n);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int i = 0; i < WORD_W / 8; i++) begin
         if (CNT_W'(i) < n) begin
            m[i*8 +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

endpackage

### rtl/core/facp_ram.sv
module facp_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/facp_plru.sv
module facp_plru #(
   parameter int NUM_LINES = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         touch_valid,
   input  logic [$clog2(NUM_LINES)-1:0] touch_way,
   output logic [$clog2(NUM_LINES)-1:0] victim_way
);

   localparam int WAY_W = $clog2(NUM_LINES);
   localparam int NODES = (1 << WAY_W) - 1;

   logic [NODES-1:0] tree_ff;
   logic [NODES-1:0] tree_in;

   // Walk from the root; a branch with no existing line falls back to the left.
   always_comb begin
      logic [WAY_W:0]   node;
      logic [WAY_W:0]   cand;
      logic [WAY_W-1:0] way;
      logic             b;
      node = '0;
      way  = '0;
      for (int l = WAY_W; l > 0; l--) begin
         b    = tree_ff[node[WAY_W-1:0]];
         cand = {1'b0, way} | ((WAY_W+1)'(b) << (l - 1));
         if (cand >= (WAY_W+1)'(NUM_LINES)) begin
            b = 1'b0;
         end
         way[l-1] = b;
         node     = (node << 1) + (WAY_W+1)'(1) + (WAY_W+1)'(b);
      end
      victim_way = way;
   end

   // Touch: every node on the path points away from the touched line.
   always_comb begin
      logic [WAY_W:0] node;
      logic           b;
      tree_in = tree_ff;
      node    = '0;
      for (int l = WAY_W; l > 0; l--) begin
         b = touch_way[l-1];
         tree_in[node[WAY_W-1:0]] = ~b;
         node = (node << 1) + (WAY_W+1)'(1) + (WAY_W+1)'(b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tree_ff <= '0;
      end else if (touch_valid) begin
         tree_ff <= tree_in;
      end
   end

endmodule

### rtl/core/fully_associative_cache_plru_top.sv
// Channel | Direction | Handshake           | Word
// req     | in        | req_valid/req_ready | operation, tag, byte_offset, byte_count, write_data
// rsp     | out       | rsp_valid/rsp_ready | status, read_data, victim_tag, victim_dirty, victim_data
//
// One tag comparator scans the lines in order, each read from the line RAM and then compared.
// A read/write stops at the first hit; a miss is reported after the last line.
// Fill: victim read, install, response. Bad span or unused op goes straight to the response.
// req_ready is high only while the sequencer is idle; a pending response holds the
// finished word until rsp_ready. Synchronous reset clears valid, dirty and PLRU state.
module fully_associative_cache_plru_top #(
   parameter int LINE_BYTES = 8,
   parameter int NUM_LINES  = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [facp_pkg::OP_W-1:0]    req_operation,
   input  logic [facp_pkg::TAG_W-1:0]   req_tag,
   input  logic [facp_pkg::OFF_W-1:0]   req_byte_offset,
   input  logic [facp_pkg::CNT_W-1:0]   req_byte_count,
   input  logic [facp_pkg::WORD_W-1:0]  req_write_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [facp_pkg::STAT_W-1:0]  rsp_status,
   output logic [facp_pkg::WORD_W-1:0]  rsp_read_data,
   output logic [facp_pkg::TAG_W-1:0]   rsp_victim_tag,
   output logic                         rsp_victim_dirty,
   output logic [facp_pkg::WORD_W-1:0]  rsp_victim_data
);

   import facp_pkg::*;

   localparam int WAY_W  = $clog2(NUM_LINES);
   localparam int LINE_W = 8 * LINE_BYTES;
   localparam int ENT_W  = TAG_W + LINE_W;
   localparam logic [OFF_W-1:0] OFF_MASK = OFF_W'((1 << $clog2(LINE_BYTES)) - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_CMP,
      S_FILL_RD,
      S_FILL_WR,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [OP_W-1:0]      op_ff, op_in;
   logic [TAG_W-1:0]     tag_ff, tag_in;
   logic [OFF_W-1:0]     off_ff, off_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [WORD_W-1:0]    wdata_ff, wdata_in;
   logic [WAY_W-1:0]     idx_ff, idx_in;
   logic [WAY_W-1:0]     vict_ff, vict_in;
   logic [NUM_LINES-1:0] valid_ff, valid_in;
   logic [NUM_LINES-1:0] dirty_ff, dirty_in;

   logic [STAT_W-1:0]    res_status_ff, res_status_in;
   logic [WORD_W-1:0]    res_rdata_ff, res_rdata_in;
   logic [TAG_W-1:0]     res_vtag_ff, res_vtag_in;
   logic                 res_vdirty_ff, res_vdirty_in;
   logic [WORD_W-1:0]    res_vdata_ff, res_vdata_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0]    rsp_rdata_ff, rsp_rdata_in;
   logic [TAG_W-1:0]     rsp_vtag_ff, rsp_vtag_in;
   logic                 rsp_vdirty_ff, rsp_vdirty_in;
   logic [WORD_W-1:0]    rsp_vdata_ff, rsp_vdata_in;

   logic                 ram_we;
   logic [WAY_W-1:0]     ram_addr;
   logic [ENT_W-1:0]     ram_wdata;
   logic [ENT_W-1:0]     ram_rdata;
   logic [TAG_W-1:0]     rd_tag;
   logic [WORD_W-1:0]    rd_line;

   logic                 touch_valid;
   logic [WAY_W-1:0]     touch_way;
   logic [WAY_W-1:0]     plru_victim;

   logic                 req_fire;
   logic [OFF_W-1:0]     req_off;
   logic                 span_ok;
   logic                 hit;
   logic [WORD_W-1:0]    mask;
   logic [5:0]           shamt;
   logic [WORD_W-1:0]    merged;

   facp_ram #(
      .WIDTH (ENT_W),
      .DEPTH (NUM_LINES)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   facp_plru #(
      .NUM_LINES (NUM_LINES)
   ) u_plru (
      .clock       (clock),
      .reset       (reset),
      .touch_valid (touch_valid),
      .touch_way   (touch_way),
      .victim_way  (plru_victim)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign req_off   = req_byte_offset & OFF_MASK;
   assign span_ok   = (req_byte_count != '0)
                   && ((5'(req_off) + 5'(req_byte_count)) <= 5'(LINE_BYTES));

   assign rd_tag  = ram_rdata[ENT_W-1 -: TAG_W];
   assign rd_line = WORD_W'(ram_rdata[LINE_W-1:0]);
   assign hit     = valid_ff[idx_ff] && (rd_tag == tag_ff);
   assign mask    = lane_mask(cnt_ff);
   assign shamt   = {off_ff, 3'b000};
   assign merged  = (rd_line & ~(mask << shamt)) | ((wdata_ff & mask) << shamt);

   always_comb begin
      ram_addr  = idx_ff;
      ram_we    = 1'b0;
      ram_wdata = {tag_ff, merged[LINE_W-1:0]};
      if (state_ff == S_FILL_RD || state_ff == S_FILL_WR) begin
         ram_addr = vict_ff;
      end
      if (state_ff == S_FILL_WR) begin
         ram_we    = 1'b1;
         ram_wdata = {tag_ff, wdata_ff[LINE_W-1:0]};
      end else if (state_ff == S_CMP && hit && op_ff == OP_WRITE) begin
         ram_we = 1'b1;
      end
   end

   assign touch_valid = (state_ff == S_FILL_WR) || (state_ff == S_CMP && hit);
   assign touch_way   = (state_ff == S_FILL_WR) ? vict_ff : idx_ff;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      tag_in        = tag_ff;
      off_in        = off_ff;
      cnt_in        = cnt_ff;
      wdata_in      = wdata_ff;
      idx_in        = idx_ff;
      vict_in       = vict_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      res_status_in = res_status_ff;
      res_rdata_in  = res_rdata_ff;
      res_vtag_in   = res_vtag_ff;
      res_vdirty_in = res_vdirty_ff;
      res_vdata_in  = res_vdata_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_vtag_in   = rsp_vtag_ff;
      rsp_vdirty_in = rsp_vdirty_ff;
      rsp_vdata_in  = rsp_vdata_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in         = req_operation;
               tag_in        = req_tag;
               off_in        = req_off;
               cnt_in        = req_byte_count;
               wdata_in      = req_write_data;
               idx_in        = '0;
               vict_in       = plru_victim;
               res_status_in = STAT_INVALID;
               res_rdata_in  = '0;
               res_vtag_in   = '0;
               res_vdirty_in = 1'b0;
               res_vdata_in  = '0;
               if (req_operation == OP_FILL) begin
                  state_in = S_FILL_RD;
               end else if ((req_operation == OP_READ || req_operation == OP_WRITE)
                            && span_ok) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_READ: begin
            state_in = S_CMP;
         end
         S_CMP: begin
            if (hit) begin
               res_status_in = STAT_HIT;
               if (op_ff == OP_READ) begin
                  res_rdata_in = (rd_line >> shamt) & mask;
               end else begin
                  dirty_in[idx_ff] = 1'b1;
               end
               state_in = S_DONE;
            end else if (idx_ff == WAY_W'(NUM_LINES - 1)) begin
               res_status_in = STAT_MISS;
               state_in      = S_DONE;
            end else begin
               idx_in   = idx_ff + WAY_W'(1);
               state_in = S_READ;
            end
         end
         S_FILL_RD: begin
            state_in = S_FILL_WR;
         end
         S_FILL_WR: begin
            // an invalid victim line leaves the victim fields at zero
            res_status_in = STAT_FILLED;
            if (valid_ff[vict_ff]) begin
               res_vtag_in   = rd_tag;
               res_vdata_in  = rd_line;
               res_vdirty_in = dirty_ff[vict_ff];
            end
            valid_in[vict_ff] = 1'b1;
            dirty_in[vict_ff] = 1'b0;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_rdata_in  = res_rdata_ff;
               rsp_vtag_in   = res_vtag_ff;
               rsp_vdirty_in = res_vdirty_ff;
               rsp_vdata_in  = res_vdata_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
      end
      op_ff         <= op_in;
      tag_ff        <= tag_in;
      off_ff        <= off_in;
      cnt_ff        <= cnt_in;
      wdata_ff      <= wdata_in;
      idx_ff        <= idx_in;
      vict_ff       <= vict_in;
      res_status_ff <= res_status_in;
      res_rdata_ff  <= res_rdata_in;
      res_vtag_ff   <= res_vtag_in;
      res_vdirty_ff <= res_vdirty_in;
      res_vdata_ff  <= res_vdata_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_vtag_ff   <= rsp_vtag_in;
      rsp_vdirty_ff <= rsp_vdirty_in;
      rsp_vdata_ff  <= rsp_vdata_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_read_data    = rsp_rdata_ff;
   assign rsp_victim_tag   = rsp_vtag_ff;
   assign rsp_victim_dirty = rsp_vdirty_ff;
   assign rsp_victim_data  = rsp_vdata_ff;

endmodule

### rtl/core/facp_checker.sv
`include "assert_macros.svh"

module facp_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [facp_pkg::STAT_W-1:0]  rsp_status,
   input logic [facp_pkg::WORD_W-1:0]  rsp_read_data,
   input logic [facp_pkg::TAG_W-1:0]   rsp_victim_tag,
   input logic                         rsp_victim_dirty,
   input logic [facp_pkg::WORD_W-1:0]  rsp_victim_data
);

   import facp_pkg::*;

   // a stalled response word holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_read_data) && $stable(rsp_victim_data))

   // one word in flight: busy right after an accept
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // victim fields only carry data on a fill
   `ASSERT_NOW(a_victim_zero, clock, reset, rsp_valid && rsp_status != STAT_FILLED, rsp_victim_tag == '0 && rsp_victim_data == '0 && !rsp_victim_dirty)

   // read data only on a hit
   `ASSERT_NOW(a_rdata_zero, clock, reset, rsp_valid && rsp_status != STAT_HIT, rsp_read_data == '0)

endmodule

bind fully_associative_cache_plru_top facp_checker u_checker (.*);

### tb/cache_plru_checker.sv
module cache_plru_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic [facp_pkg::OP_W-1:0]    req_operation,
   input  logic [facp_pkg::TAG_W-1:0]   req_tag,
   input  logic [facp_pkg::OFF_W-1:0]   req_byte_offset,
   input  logic [facp_pkg::CNT_W-1:0]   req_byte_count,
   input  logic [facp_pkg::WORD_W-1:0]  req_write_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic [facp_pkg::STAT_W-1:0]  rsp_status,
   input  logic [facp_pkg::WORD_W-1:0]  rsp_read_data,
   input  logic [facp_pkg::TAG_W-1:0]   rsp_victim_tag,
   input  logic                         rsp_victim_dirty,
   input  logic [facp_pkg::WORD_W-1:0]  rsp_victim_data,
   output int unsigned                  words_pending,
   output int unsigned                  error_count
);
   import facp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINES      = 8;
   localparam int LINE_SIZE  = 8;
   localparam int TREE_DEPTH = 3;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [WORD_W-1:0] read_data;
      logic [TAG_W-1:0]  victim_tag;
      logic              victim_dirty;
      logic [WORD_W-1:0] victim_data;
   } cache_rsp_type;

   logic [TAG_W-1:0]  line_tag   [LINES];
   logic              line_valid [LINES];
   logic              line_dirty [LINES];
   logic [WORD_W-1:0] line_data  [LINES];
   logic [LINES-2:0]  plru_tree;
   cache_rsp_type     expected_rsp_q[$];
   int unsigned       mismatches;

   function automatic logic [WORD_W-1:0] low_lanes(input int n);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int i = 0; i < WORD_W / 8; i++) begin
         if (i < n) begin
            m[i*8 +: 8] = 8'hff;
         end
      end
      return m;
   endfunction

   // every node on the path points away from the touched line
   function automatic void touch_line(input int way);
      int node;
      int b;
      node = 0;
      for (int lvl = TREE_DEPTH; lvl > 0; lvl--) begin
         b = (way >> (lvl - 1)) & 1;
         plru_tree[node] = (b == 0);
         node = 2 * node + 1 + b;
      end
   endfunction

   function automatic int plru_victim();
      int node;
      int way;
      int b;
      node = 0;
      way  = 0;
      for (int lvl = TREE_DEPTH; lvl > 0; lvl--) begin
         b = plru_tree[node] ? 1 : 0;
         way = way | (b << (lvl - 1));
         node = 2 * node + 1 + b;
      end
      return way;
   endfunction

   function automatic cache_rsp_type predict_access(input logic [OP_W-1:0]   op,
                                                    input logic [TAG_W-1:0]  tag,
                                                    input logic [OFF_W-1:0]  off,
                                                    input logic [CNT_W-1:0]  cnt,
                                                    input logic [WORD_W-1:0] wdata);
      cache_rsp_type     r;
      int                hit;
      int                way;
      logic [WORD_W-1:0] m;
      r = '0;
      r.status = STAT_INVALID;
      hit = -1;
      // 8-byte lines: the offset mask keeps all three offset bits
      if (op == OP_FILL) begin
         way = plru_victim();
         r.victim_tag   = line_tag[way];
         r.victim_dirty = line_valid[way] && line_dirty[way];
         r.victim_data  = line_data[way] & low_lanes(LINE_SIZE);
         line_tag[way]   = tag;
         line_valid[way] = 1'b1;
         line_dirty[way] = 1'b0;
         line_data[way]  = wdata & low_lanes(LINE_SIZE);
         touch_line(way);
         r.status = STAT_FILLED;
      end else if ((op == OP_READ || op == OP_WRITE) && cnt != '0 &&
                   int'(off) + int'(cnt) <= LINE_SIZE) begin
         // lowest matching line wins when a tag is present twice
         for (int i = LINES - 1; i >= 0; i--) begin
            if (line_valid[i] && line_tag[i] == tag) begin
               hit = i;
            end
         end
         if (hit < 0) begin
            r.status = STAT_MISS;
         end else begin
            m = low_lanes(int'(cnt));
            if (op == OP_READ) begin
               r.read_data = (line_data[hit] >> (8 * off)) & m;
            end else begin
               line_data[hit] = (line_data[hit] & ~(m << (8 * off))) |
                                ((wdata & m) << (8 * off));
               line_dirty[hit] = 1'b1;
            end
            touch_line(hit);
            r.status = STAT_HIT;
         end
      end
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [WORD_W-1:0] want,
                                       input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      cache_rsp_type exp_word;
      if (reset) begin
         for (int i = 0; i < LINES; i++) begin
            line_tag[i]   = '0;
            line_valid[i] = 1'b0;
            line_dirty[i] = 1'b0;
            line_data[i]  = '0;
         end
         plru_tree = '0;
         expected_rsp_q.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: response word with nothing expected, status %h",
                        $time, rsp_status);
               mismatches++;
            end else begin
               exp_word = expected_rsp_q.pop_front();
               check_field("status", WORD_W'(exp_word.status), WORD_W'(rsp_status));
               check_field("read_data", exp_word.read_data, rsp_read_data);
               check_field("victim_tag", WORD_W'(exp_word.victim_tag),
                           WORD_W'(rsp_victim_tag));
               check_field("victim_dirty", WORD_W'(exp_word.victim_dirty),
                           WORD_W'(rsp_victim_dirty));
               check_field("victim_data", exp_word.victim_data, rsp_victim_data);
            end
         end
         if (req_valid && req_ready) begin
            expected_rsp_q.push_back(predict_access(req_operation, req_tag,
                                                    req_byte_offset, req_byte_count,
                                                    req_write_data));
         end
      end
      words_pending <= expected_rsp_q.size();
      error_count   <= mismatches;
   end

endmodule

### tb/fully_associative_cache_plru_top_test.sv
module fully_associative_cache_plru_top_test;
   import facp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_WORDS = 950;
   localparam int TAG_POOL     = 12;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 25;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = OP_READ;
   logic [TAG_W-1:0]    req_tag = '0;
   logic [OFF_W-1:0]    req_byte_offset = '0;
   logic [CNT_W-1:0]    req_byte_count = '0;
   logic [WORD_W-1:0]   req_write_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [WORD_W-1:0]   rsp_read_data;
   logic [TAG_W-1:0]    rsp_victim_tag;
   logic                rsp_victim_dirty;
   logic [WORD_W-1:0]   rsp_victim_data;
   int unsigned         words_pending;
   int unsigned         error_count;
   int unsigned         idle_cycles = 0;

   always #5 clock = ~clock;

   fully_associative_cache_plru_top uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_tag          (req_tag),
      .req_byte_offset  (req_byte_offset),
      .req_byte_count   (req_byte_count),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data),
      .rsp_victim_tag   (rsp_victim_tag),
      .rsp_victim_dirty (rsp_victim_dirty),
      .rsp_victim_data  (rsp_victim_data)
   );

   cache_plru_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_tag          (req_tag),
      .req_byte_offset  (req_byte_offset),
      .req_byte_count   (req_byte_count),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_read_data    (rsp_read_data),
      .rsp_victim_tag   (rsp_victim_tag),
      .rsp_victim_dirty (rsp_victim_dirty),
      .rsp_victim_data  (rsp_victim_data),
      .words_pending    (words_pending),
      .error_count      (error_count)
   );

   // called at a rising edge; returns at the edge where the word is taken
   task automatic send_word(input logic [OP_W-1:0]   op,
                            input logic [TAG_W-1:0]  tag,
                            input logic [OFF_W-1:0]  off,
                            input logic [CNT_W-1:0]  cnt,
                            input logic [WORD_W-1:0] wdata);
      req_valid       <= 1'b1;
      req_operation   <= op;
      req_tag         <= tag;
      req_byte_offset <= off;
      req_byte_count  <= cnt;
      req_write_data  <= wdata;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // receiver: stall pattern changes mode now and then, plus one long hold-off
   initial begin
      int stall_mode;
      int mode_left;
      int hold_left;
      int rsp_cycle;
      stall_mode = 0;
      mode_left  = 0;
      hold_left  = 0;
      rsp_cycle  = 0;
      forever begin
         @(posedge clock);
         rsp_cycle++;
         if (rsp_cycle == 2000) hold_left = 400;
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 4);
            mode_left  = $urandom_range(10, 100);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               2: rsp_ready <= (rsp_cycle % 4 == 0);
               3: rsp_ready <= ($urandom_range(0, 9) != 0);
               default: rsp_ready <= ($urandom_range(0, 19) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [TAG_W-1:0]  tag_pool [TAG_POOL];
      logic [OP_W-1:0]   op;
      logic [TAG_W-1:0]  tag;
      logic [OFF_W-1:0]  off;
      logic [CNT_W-1:0]  cnt;
      logic [WORD_W-1:0] wdata;
      int                pick;
      int                burst;
      int                gap;
      int                sent;
      foreach (tag_pool[i]) tag_pool[i] = $urandom;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty cache, span edges, bad ops, dirty eviction, duplicate tag
      send_word(OP_READ,  32'h0000_0000, 3'd0, 4'd1, '0);
      send_word(OP_FILL,  32'hffff_ffff, 3'd0, 4'd0, 64'hffff_ffff_ffff_ffff);
      send_word(OP_READ,  32'hffff_ffff, 3'd0, 4'd8, '0);
      send_word(OP_WRITE, 32'hffff_ffff, 3'd7, 4'd1, 64'h0);
      send_word(OP_WRITE, 32'hffff_ffff, 3'd0, 4'd4, 64'hffff_ffff_0123_4567);
      send_word(OP_READ,  32'hffff_ffff, 3'd3, 4'd5, '0);
      send_word(OP_READ,  32'hffff_ffff, 3'd7, 4'd2, '0);
      send_word(OP_READ,  32'hffff_ffff, 3'd0, 4'd0, '0);
      send_word(OP_WRITE, 32'hffff_ffff, 3'd0, 4'd15, 64'hffff_ffff_ffff_ffff);
      send_word(OP_UNUSED, 32'hffff_ffff, 3'd0, 4'd8, 64'hffff_ffff_ffff_ffff);
      send_word(OP_FILL,  32'h0000_0000, 3'd0, 4'd0, 64'h1111_2222_3333_4444);
      send_word(OP_FILL,  32'ha5a5_a5a5, 3'd7, 4'd15, 64'haaaa_aaaa_aaaa_aaaa);
      send_word(OP_FILL,  32'h5a5a_5a5a, 3'd0, 4'd0, 64'h5555_5555_5555_5555);
      send_word(OP_FILL,  32'h8000_0000, 3'd0, 4'd0, 64'h8000_0000_0000_0001);
      send_word(OP_FILL,  32'h0000_0001, 3'd0, 4'd0, 64'h0);
      send_word(OP_FILL,  32'ha5a5_a5a5, 3'd0, 4'd0, 64'hbbbb_bbbb_bbbb_bbbb);
      send_word(OP_FILL,  32'h1234_5678, 3'd0, 4'd0, 64'hfedc_ba98_7654_3210);
      send_word(OP_FILL,  32'hdead_beef, 3'd0, 4'd0, 64'hcafe_f00d_0000_ffff);
      send_word(OP_READ,  32'ha5a5_a5a5, 3'd0, 4'd8, '0);
      send_word(OP_WRITE, 32'h7777_0000, 3'd2, 4'd3, 64'hffff_ffff_ffff_ffff);

      // random: bursts of mostly well-formed traffic on a small, drifting tag set
      sent = 0;
      while (sent < RANDOM_WORDS) begin
         burst = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(1, 10);
         for (int k = 0; k < burst; k++) begin
            pick  = $urandom_range(0, 99);
            tag   = tag_pool[$urandom_range(0, TAG_POOL - 1)];
            off   = OFF_W'($urandom_range(0, 7));
            cnt   = CNT_W'($urandom_range(1, 8 - int'(off)));
            wdata = {$urandom, $urandom};
            if (pick < 15) begin
               op = OP_FILL;
            end else if (pick < 55) begin
               op = OP_READ;
            end else if (pick < 85) begin
               op = OP_WRITE;
            end else if (pick < 92) begin
               op  = $urandom_range(0, 1) ? OP_WRITE : OP_READ;
               tag = $urandom;
            end else begin
               op  = OP_W'($urandom_range(0, 3));
               cnt = CNT_W'($urandom_range(0, 15));
               if ($urandom_range(0, 1)) tag = $urandom;
            end
            if ($urandom_range(0, 29) == 0) tag_pool[$urandom_range(0, TAG_POOL - 1)] = $urandom;
            send_word(op, tag, off, cnt, wdata);
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/facp_pkg.sv
rtl/core/facp_ram.sv
rtl/core/facp_plru.sv
rtl/core/fully_associative_cache_plru_top.sv
rtl/core/facp_checker.sv
tb/cache_plru_checker.sv
tb/fully_associative_cache_plru_top_test.sv
